/* design/lfu_cache_lru_tiebreak_assert.svh */
// ----------------------------------------------------------------------------
// LFU cache assertion macros
// Concurrent assertion helpers for the LFU cache. The checks compile only
// in simulation builds; SYNTH builds get empty bodies.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH

`ifndef SYNTH

`define LFULRU_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lfulru assertion failed");

`define LFULRU_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("lfulru forbidden condition seen");

`else

`define LFULRU_ASSERT(name, clk, rst, prop)

`define LFULRU_NEVER(name, clk, rst, cond)

`endif

`endif

/* design/lfulru_pkg.sv */
// ----------------------------------------------------------------------------
// LFU cache package
// Shared widths, defaults and register map for the LFU cache.
// ----------------------------------------------------------------------------
package lfulru_pkg;

   localparam int ENTRIES_DEF    = 16;
   localparam int COUNT_BITS_DEF = 16;

   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int STAMP_BITS = 48;
   localparam int CAP_BITS   = 5;
   localparam int DATA_BITS  = 32;
   localparam int ADDR_BITS  = 3;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

   localparam logic [ADDR_BITS-3:0] REG_CAPACITY = '0;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

endpackage

/* design/lfulru_csr.sv */
// ----------------------------------------------------------------------------
// LFU cache register block
// APB-style register port holding the capacity register.
// ----------------------------------------------------------------------------
module lfulru_csr
   import lfulru_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready,
   output logic [CAP_BITS-1:0]  capacity
);

   logic [CAP_BITS-1:0]  capacity_ff;
   logic [ADDR_BITS-3:0] reg_index;
   logic                 wr_cap;

   assign pready    = 1'b1;
   assign reg_index = paddr[ADDR_BITS-1:2];
   assign wr_cap    = psel && penable && pwrite && (reg_index == REG_CAPACITY);
   assign capacity  = capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (wr_cap) begin
         capacity_ff <= pwdata[CAP_BITS-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_index == REG_CAPACITY) begin
         prdata = {{(DATA_BITS-CAP_BITS){1'b0}}, capacity_ff};
      end
   end

endmodule

/* design/lfu_cache_lru_tiebreak.sv */
// ----------------------------------------------------------------------------
// LFU cache with LRU tie-break
// Fully associative key/value cache, least-frequently-used replacement,
// oldest touch loses among equal counts. Entries live in one memory.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  command, key, write_value
//   rsp      out        rsp_valid/rsp_stall  hit, read_value, evicted, key
//   csr      in/out     psel/penable/pready  capacity
//
// After accept a request passes S_SCAN (a sweep reading one entry at a time),
// S_DRAIN (drain the read), S_UPDATE (decide and write back) and S_RESP (load
// the output). The next request is taken only back in S_IDLE, after S_RESP.
// With capacity zero the request goes straight from S_IDLE to S_RESP as a miss.
// Reset clears the valid bits but not the entry memory; no clearing pass.
// A stalled result holds the output register; the next request waits in S_RESP.
// ----------------------------------------------------------------------------
`include "lfu_cache_lru_tiebreak_assert.svh"

module lfu_cache_lru_tiebreak
   import lfulru_pkg::*;
#(
   parameter int ENTRIES    = ENTRIES_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_command,
   input  logic [KEY_BITS-1:0]          req_key,
   input  logic signed [VALUE_BITS-1:0] req_write_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit,
   output logic signed [VALUE_BITS-1:0] rsp_read_value,
   output logic                         rsp_evicted,
   output logic [KEY_BITS-1:0]          rsp_evicted_key,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [ADDR_BITS-1:0]         paddr,
   input  logic [DATA_BITS-1:0]         pwdata,
   output logic [DATA_BITS-1:0]         prdata,
   output logic                         pready
);

   localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_BITS  = $clog2(ENTRIES + 1);
   localparam int CMP_BITS  = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;
   localparam int WORD_BITS = KEY_BITS + VALUE_BITS + COUNT_BITS + STAMP_BITS;
   localparam int CNT_LO    = STAMP_BITS;
   localparam int VAL_LO    = CNT_LO + COUNT_BITS;
   localparam int KEY_LO    = VAL_LO + VALUE_BITS;

   localparam logic [IDX_BITS-1:0]   LAST_IDX    = IDX_BITS'(ENTRIES - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE   = COUNT_BITS'(1);
   localparam logic [CMP_BITS-1:0]   ENTRIES_CMP = CMP_BITS'(ENTRIES);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_UPDATE,
      S_RESP
   } state_type;

   // configuration
   logic [CAP_BITS-1:0] capacity;

   lfulru_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .capacity (capacity)
   );

   // entry memory
   logic [WORD_BITS-1:0] mem [ENTRIES];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 mem_we;
   logic [WORD_BITS-1:0] upd_word;

   // control and working registers
   state_type                    state_ff;
   logic [IDX_BITS-1:0]          addr_ff;
   logic                         chk_ff;
   logic [IDX_BITS-1:0]          chk_idx_ff;
   logic [ENTRIES-1:0]           valid_ff;
   logic [STAMP_BITS-1:0]        stamp_ff;
   logic                         cmd_ff;
   logic [KEY_BITS-1:0]          key_ff;
   logic signed [VALUE_BITS-1:0] wval_ff;
   logic                         found_ff;
   logic [IDX_BITS-1:0]          found_idx_ff;
   logic signed [VALUE_BITS-1:0] found_val_ff;
   logic [COUNT_BITS-1:0]        found_cnt_ff;
   logic [OCC_BITS-1:0]          occ_ff;
   logic                         free_ff;
   logic [IDX_BITS-1:0]          free_idx_ff;
   logic                         vic_ff;
   logic [IDX_BITS-1:0]          vic_idx_ff;
   logic [COUNT_BITS-1:0]        vic_cnt_ff;
   logic [STAMP_BITS-1:0]        vic_stamp_ff;
   logic [KEY_BITS-1:0]          vic_key_ff;
   logic                         res_hit_ff;
   logic signed [VALUE_BITS-1:0] res_val_ff;
   logic                         res_ev_ff;
   logic [KEY_BITS-1:0]          res_evkey_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_hit_ff;
   logic signed [VALUE_BITS-1:0] rsp_val_ff;
   logic                         rsp_ev_ff;
   logic [KEY_BITS-1:0]          rsp_evkey_ff;

   // scan-side decode
   logic [KEY_BITS-1:0]          rd_key;
   logic signed [VALUE_BITS-1:0] rd_val;
   logic [COUNT_BITS-1:0]        rd_cnt;
   logic [STAMP_BITS-1:0]        rd_stamp;
   logic                         rd_valid_bit;
   logic                         rd_match;
   logic                         rd_better;

   // update-side decode
   logic [CMP_BITS-1:0]          cap_ext;
   logic [CMP_BITS-1:0]          cap_eff;
   logic                         full;
   logic                         upd_write;
   logic                         upd_evict;
   logic [IDX_BITS-1:0]          upd_slot;
   logic signed [VALUE_BITS-1:0] upd_val;
   logic [COUNT_BITS-1:0]        upd_cnt;

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_val_ff;
   assign rsp_evicted     = rsp_ev_ff;
   assign rsp_evicted_key = rsp_evkey_ff;

   always_comb begin
      rd_key       = rd_data_ff[KEY_LO +: KEY_BITS];
      rd_val       = signed'(rd_data_ff[VAL_LO +: VALUE_BITS]);
      rd_cnt       = rd_data_ff[CNT_LO +: COUNT_BITS];
      rd_stamp     = rd_data_ff[0 +: STAMP_BITS];
      rd_valid_bit = valid_ff[chk_idx_ff];
      rd_match     = chk_ff && rd_valid_bit && (rd_key == key_ff);
      rd_better    = !vic_ff || (rd_cnt < vic_cnt_ff) ||
                     ((rd_cnt == vic_cnt_ff) && (rd_stamp < vic_stamp_ff));
   end

   always_comb begin
      cap_ext   = CMP_BITS'(capacity);
      cap_eff   = (cap_ext > ENTRIES_CMP) ? ENTRIES_CMP : cap_ext;
      full      = (CMP_BITS'(occ_ff) >= cap_eff);
      upd_write = 1'b0;
      upd_evict = 1'b0;
      upd_slot  = found_idx_ff;
      upd_val   = wval_ff;
      upd_cnt   = COUNT_ONE;
      if (found_ff) begin
         upd_write = 1'b1;
         upd_val   = (cmd_ff == CMD_PUT) ? wval_ff : found_val_ff;
         upd_cnt   = (found_cnt_ff == COUNT_MAX) ? COUNT_MAX : found_cnt_ff + COUNT_ONE;
      end else if (cmd_ff == CMD_PUT) begin
         upd_write = 1'b1;
         if (full) begin
            upd_evict = 1'b1;
            upd_slot  = vic_idx_ff;
         end else begin
            upd_slot  = free_idx_ff;
         end
      end
      upd_word = {key_ff, upd_val, upd_cnt, stamp_ff};
      mem_we   = (state_ff == S_UPDATE) && upd_write;
   end

   // reads are swept only after the previous write-back, so no forwarding
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[addr_ff];
      if (mem_we) begin
         mem[upd_slot] <= upd_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chk_ff       <= 1'b0;
         valid_ff     <= '0;
         stamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         chk_ff     <= (state_ff == S_SCAN);
         chk_idx_ff <= addr_ff;

         if (chk_ff) begin
            occ_ff <= occ_ff + OCC_BITS'(rd_valid_bit);
            if (rd_match) begin
               found_ff     <= 1'b1;
               found_idx_ff <= chk_idx_ff;
               found_val_ff <= rd_val;
               found_cnt_ff <= rd_cnt;
            end
            if (!free_ff && !rd_valid_bit) begin
               free_ff     <= 1'b1;
               free_idx_ff <= chk_idx_ff;
            end
            if (rd_valid_bit && rd_better) begin
               vic_ff       <= 1'b1;
               vic_idx_ff   <= chk_idx_ff;
               vic_cnt_ff   <= rd_cnt;
               vic_stamp_ff <= rd_stamp;
               vic_key_ff   <= rd_key;
            end
         end

         if ((state_ff == S_RESP) && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= req_command;
                  key_ff   <= req_key;
                  wval_ff  <= req_write_value;
                  found_ff <= 1'b0;
                  free_ff  <= 1'b0;
                  vic_ff   <= 1'b0;
                  occ_ff   <= '0;
                  addr_ff  <= '0;
                  if (capacity == '0) begin
                     res_hit_ff   <= 1'b0;
                     res_val_ff   <= '0;
                     res_ev_ff    <= 1'b0;
                     res_evkey_ff <= '0;
                     state_ff     <= S_RESP;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               addr_ff <= addr_ff + IDX_BITS'(1);
               if (addr_ff == LAST_IDX) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               res_hit_ff   <= found_ff;
               res_val_ff   <= (found_ff && cmd_ff == CMD_GET) ? found_val_ff : '0;
               res_ev_ff    <= upd_evict;
               res_evkey_ff <= upd_evict ? vic_key_ff : '0;
               if (upd_write) begin
                  valid_ff[upd_slot] <= 1'b1;
                  stamp_ff           <= stamp_ff + STAMP_BITS'(1);
               end
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_hit_ff   <= res_hit_ff;
                  rsp_val_ff   <= res_val_ff;
                  rsp_ev_ff    <= res_ev_ff;
                  rsp_evkey_ff <= res_evkey_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   `LFULRU_ASSERT(a_accept_then_stall, clock, reset, (req_valid && !req_stall) |=> req_stall)
   `LFULRU_ASSERT(a_occ_matches_valid, clock, reset, (state_ff == S_UPDATE) |-> (occ_ff == $countones(valid_ff)))
   `LFULRU_ASSERT(a_victim_known, clock, reset, (state_ff == S_UPDATE && upd_evict) |-> vic_ff)
   `LFULRU_NEVER(a_hit_no_evict, clock, reset, rsp_valid && rsp_hit && rsp_evicted)

endmodule
